// ===== src/assert_macros.svh =====
// Assertion macros used by the checker file of the line decoder
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low
`define ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication, sampled on clk, off while rst_n is low
`define ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

// ===== src/hdbn_pkg.sv =====
// Shared constants and types for the HDBn line decoder
package hdbn_pkg;

    localparam int MAX_ORDER   = 4;
    localparam int MIN_ORDER   = 2;
    localparam int MAX_RESULTS = MAX_ORDER + 1;
    localparam int ORDER_W     = 3;
    localparam logic [ORDER_W-1:0] ORDER_RESET = 3'd3;

    localparam int HCNT_W    = $clog2(MAX_ORDER + 1);
    localparam int RCNT_W    = $clog2(MAX_RESULTS + 1);
    localparam int BUF_DEPTH = MAX_RESULTS + 3;
    localparam int BCNT_W    = $clog2(BUF_DEPTH + 1);
    localparam int BUF_ROOM  = BUF_DEPTH - MAX_RESULTS;

    typedef enum logic {
        POL_NEG = 1'b0,
        POL_POS = 1'b1
    } pol_t;

    typedef struct packed {
        logic pos_pulse;
        logic neg_pulse;
        logic message_end;
    } sym_req_t;

    typedef struct packed {
        logic decoded_bit;
        logic last_of_run;
    } res_t;

    typedef struct packed {
        res_t [MAX_RESULTS-1:0] item;
        logic [RCNT_W-1:0]      cnt;
    } res_batch_t;

endpackage

// ===== src/hdbn_sym_dec.sv =====
// Symbol decode: violation handling, held-bit delay line and result batch
module hdbn_sym_dec
    import hdbn_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               adv,
    input  sym_req_t           sym,
    input  logic [ORDER_W-1:0] order,
    output res_batch_t         batch
);

    logic [MAX_ORDER-1:0] held_reg, held_next;
    logic [HCNT_W-1:0]    hcnt_reg, hcnt_next;
    pol_t                 pol_reg, pol_next;

    logic                 sym_nz;
    logic                 viol;
    logic                 dbit;
    logic [MAX_ORDER-1:0] cleared;
    int                   n_i;
    int                   hc_i;
    int                   emit_i;

    // Clamp the order into the supported range
    always_comb
    begin
        n_i = int'(order);
        if (n_i < MIN_ORDER)
            n_i = MIN_ORDER;
        if (n_i > MAX_ORDER)
            n_i = MAX_ORDER;
    end

    // Classify the symbol against the last pulse polarity
    assign sym_nz = sym.pos_pulse ^ sym.neg_pulse;
    assign viol   = sym_nz && (pol_t'(sym.pos_pulse) == pol_reg);
    assign dbit   = sym_nz && !viol;
    assign hc_i   = int'(hcnt_reg);
    assign emit_i = (hc_i >= n_i) ? (hc_i - n_i + 1) : 0;

    // Drop the most recent held bits on a violation
    always_comb
    begin
        for (int i = 0; i < MAX_ORDER; i++)
        begin
            cleared[i] = held_reg[i] & ~(viol && (i < hc_i) && (i + n_i >= hc_i));
        end
    end

    // Build the batch of results released by this symbol
    always_comb
    begin
        for (int j = 0; j < MAX_RESULTS; j++)
        begin
            if ((j < MAX_ORDER) && (j < hc_i))
                batch.item[j].decoded_bit = cleared[j];
            else
                batch.item[j].decoded_bit = dbit;
            batch.item[j].last_of_run = sym.message_end && (j == hc_i);
        end
        if (sym.message_end)
            batch.cnt = RCNT_W'(hcnt_reg) + RCNT_W'(1);
        else
            batch.cnt = RCNT_W'(emit_i);
    end

    // Advance the delay line and polarity
    always_comb
    begin
        held_next = '0;
        hcnt_next = '0;
        pol_next  = POL_NEG;
        if (!sym.message_end)
        begin
            for (int i = 0; i < MAX_ORDER; i++)
            begin
                if ((i + emit_i < hc_i) && (i + emit_i < MAX_ORDER))
                    held_next[i] = cleared[i + emit_i];
                else if (i + emit_i == hc_i)
                    held_next[i] = dbit;
                else
                    held_next[i] = 1'b0;
            end
            hcnt_next = HCNT_W'(hc_i - emit_i + 1);
            pol_next  = dbit ? pol_t'(sym.pos_pulse) : pol_reg;
        end
    end

    // Hold state until a symbol advances
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg <= '0;
            hcnt_reg <= '0;
            pol_reg  <= POL_NEG;
        end
        else if (adv)
        begin
            held_reg <= held_next;
            hcnt_reg <= hcnt_next;
            pol_reg  <= pol_next;
        end
    end

endmodule

// ===== src/hdbn_res_buf.sv =====
// Result buffer: takes a batch of results per cycle on push, releases one per cycle on pop
module hdbn_res_buf
    import hdbn_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  res_batch_t batch,
    input  logic       pop,
    output logic       room,
    output logic       out_valid,
    output res_t       head
);

    res_t [BUF_DEPTH-1:0] q_reg, q_next;
    logic [BCNT_W-1:0]    cnt_reg, cnt_next;
    int                   base_i;
    int                   j;

    assign base_i = int'(cnt_reg) - (pop ? 1 : 0);

    // Shift out the head on a pop and append the new batch behind the rest
    always_comb
    begin
        j = 0;
        for (int i = 0; i < BUF_DEPTH; i++)
        begin
            if (pop && (i + 1 < BUF_DEPTH))
                q_next[i] = q_reg[i + 1];
            else
                q_next[i] = q_reg[i];
            j = i - base_i;
            if (push && (j >= 0) && (j < int'(batch.cnt)) && (j < MAX_RESULTS))
                q_next[i] = batch.item[j];
        end
        cnt_next = cnt_reg - BCNT_W'(pop) + (push ? BCNT_W'(batch.cnt) : BCNT_W'(0));
    end

    // Hold the entry count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else
            cnt_reg <= cnt_next;
    end

    // Hold the entries
    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
    end

    assign room      = (int'(cnt_reg) <= BUF_ROOM);
    assign out_valid = (cnt_reg != '0);
    assign head      = q_reg[0];

endmodule

// ===== src/hdbn_line_decoder.sv =====
// A symbol in the input register enters the result buffer when it advances; its bits leave
// after the order-n hold. Throughput: one symbol per cycle unless in_stall is high;
// one bit per cycle leaves the result buffer unless out_stall is high. Input stalls while the
// eight-entry buffer holds over three, leaving room for a message end (up to five bits).
// Reset (rst_n low, asynchronous): buffers empty, no bits held, polarity negative, order 3.
// Top level of the HDBn line decoder
module hdbn_line_decoder
    import hdbn_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               pos_pulse,
    input  logic               neg_pulse,
    input  logic               message_end,
    input  logic               order_we,
    input  logic [ORDER_W-1:0] order_wdata,
    output logic               out_valid,
    input  logic               out_stall,
    output logic               decoded_bit,
    output logic               last_of_run
);

    logic [ORDER_W-1:0] order_reg;
    logic               sym_vld_reg;
    sym_req_t           sym_reg;
    logic               room;
    logic               adv;
    logic               pop;
    res_batch_t         batch;
    res_t               head;

    // Hold the code order register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            order_reg <= ORDER_RESET;
        else if (order_we)
            order_reg <= order_wdata;
    end

    // Advance the input request when the result buffer has room for a full batch
    assign adv      = sym_vld_reg && room;
    assign in_stall = sym_vld_reg && !room;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sym_vld_reg <= 1'b0;
        else if (!in_stall)
            sym_vld_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            sym_reg.pos_pulse   <= pos_pulse;
            sym_reg.neg_pulse   <= neg_pulse;
            sym_reg.message_end <= message_end;
        end
    end

    hdbn_sym_dec u_dec (
        .clk   (clk),
        .rst_n (rst_n),
        .adv   (adv),
        .sym   (sym_reg),
        .order (order_reg),
        .batch (batch)
    );

    // Drop the head result once the request is taken
    assign pop = out_valid && !out_stall;

    hdbn_res_buf u_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (adv),
        .batch     (batch),
        .pop       (pop),
        .room      (room),
        .out_valid (out_valid),
        .head      (head)
    );

    assign decoded_bit = head.decoded_bit;
    assign last_of_run = head.last_of_run;

endmodule

// ===== src/hdbn_chk.sv =====
// Port-level checker for the HDBn line decoder, bound to the top level
`include "assert_macros.svh"

module hdbn_chk
(
    input logic clk,
    input logic rst_n,
    input logic in_stall,
    input logic out_valid,
    input logic out_stall,
    input logic decoded_bit,
    input logic last_of_run
);

    // Input backpressure only comes from a well-filled result buffer
    `ASSERT_IMP(a_stall_has_out, in_stall, out_valid)
    // A buffer deep enough to stall still holds a result in the following cycle
    `ASSERT_NXT(a_stall_then_out, in_stall, out_valid)
    // A stalled result request stays up with an unchanged payload
    `ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid)
    `ASSERT_NXT(a_out_stable, out_valid && out_stall, $stable(decoded_bit) && $stable(last_of_run))

endmodule

bind hdbn_line_decoder hdbn_chk u_chk (.*);

// ===== verif/tb_top.sv =====
// Self-checking testbench for the HDBn line decoder: directed and random symbol traffic
module tb_top;
    import hdbn_pkg::*;

    logic               clk         = 1'b0;
    logic               rst_n       = 1'b0;
    logic               in_valid    = 1'b0;
    logic               pos_pulse   = 1'b0;
    logic               neg_pulse   = 1'b0;
    logic               message_end = 1'b0;
    logic               order_we    = 1'b0;
    logic [ORDER_W-1:0] order_wdata = '0;
    logic               out_stall   = 1'b0;
    logic               in_stall;
    logic               out_valid;
    logic               decoded_bit;
    logic               last_of_run;

    // Decoder mirror: held bits (index 0 oldest), polarity and order register
    logic [MAX_ORDER-1:0] hold_bits;
    int                   hold_count;
    pol_t                 line_pol;
    logic [ORDER_W-1:0]   order_sel;

    res_t expected_bits[$];
    int   fail_count = 0;
    int   in_calm    = 0;
    int   out_calm   = 0;

    hdbn_line_decoder u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .pos_pulse   (pos_pulse),
        .neg_pulse   (neg_pulse),
        .message_end (message_end),
        .order_we    (order_we),
        .order_wdata (order_wdata),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .decoded_bit (decoded_bit),
        .last_of_run (last_of_run)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Draw a random wait, with occasional stretches of no waiting at all
    function automatic int draw_wait(inout int calm_left);
        if (calm_left > 0)
        begin
            calm_left--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0)
        begin
            calm_left = $urandom_range(10, 40);
            return 0;
        end
        return $urandom_range(0, 15);
    endfunction

    function automatic void clear_line();
        hold_bits  = '0;
        hold_count = 0;
        line_pol   = POL_NEG;
    endfunction

    // Decode one line symbol and queue the bits it releases
    function automatic void decode_symbol(input logic p, input logic q, input logic e);
        int   n;
        int   k;
        int   i;
        logic bit_val;
        res_t r;
        n = int'(order_sel);
        if (n < MIN_ORDER)
            n = MIN_ORDER;
        if (n > MAX_ORDER)
            n = MAX_ORDER;
        bit_val = 1'b0;
        if (p != q)
        begin
            if (pol_t'(p) == line_pol)
            begin
                // violation: zero the newest held bits, keep the polarity
                k = (n < hold_count) ? n : hold_count;
                for (i = 0; i < k; i++)
                    hold_bits[hold_count - 1 - i] = 1'b0;
            end
            else
            begin
                line_pol = pol_t'(p);
                bit_val  = 1'b1;
            end
        end
        if (e)
        begin
            // flush everything held, then the current bit marked as last
            for (i = 0; i < hold_count; i++)
            begin
                r.decoded_bit = hold_bits[i];
                r.last_of_run = 1'b0;
                expected_bits.push_back(r);
            end
            r.decoded_bit = bit_val;
            r.last_of_run = 1'b1;
            expected_bits.push_back(r);
            clear_line();
        end
        else
        begin
            // release the oldest bits until fewer than n remain
            while (hold_count >= n)
            begin
                r.decoded_bit = hold_bits[0];
                r.last_of_run = 1'b0;
                expected_bits.push_back(r);
                hold_bits = hold_bits >> 1;
                hold_count--;
            end
            hold_bits[hold_count] = bit_val;
            hold_count++;
        end
    endfunction

    // Present one symbol request and hold it until accepted
    task automatic send_symbol(input logic p, input logic q, input logic e);
        int gap;
        gap = draw_wait(in_calm);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        pos_pulse   <= p;
        neg_pulse   <= q;
        message_end <= e;
        do
        begin
            @(posedge clk);
        end
        while (in_stall);
        decode_symbol(p, q, e);
    endtask

    // Drain the decoder, then write the order register
    task automatic write_order(input logic [ORDER_W-1:0] val);
        in_valid <= 1'b0;
        while (expected_bits.size() != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);
        order_we    <= 1'b1;
        order_wdata <= val;
        @(posedge clk);
        order_we  <= 1'b0;
        order_sel = val;
    endtask

    // Reset order: violation with nothing held, both pulses, clearing a full hold, flush
    task automatic test_reset_defaults();
        send_symbol(1'b0, 1'b1, 1'b0);
        send_symbol(1'b1, 1'b0, 1'b0);
        send_symbol(1'b0, 1'b1, 1'b0);
        send_symbol(1'b1, 1'b1, 1'b0);
        send_symbol(1'b0, 1'b0, 1'b0);
        send_symbol(1'b0, 1'b1, 1'b0);
        send_symbol(1'b0, 1'b0, 1'b1);
    endtask

    // Orders below and above the legal range saturate
    task automatic test_order_saturation();
        write_order(3'd0);
        send_symbol(1'b1, 1'b0, 1'b0);
        send_symbol(1'b0, 1'b0, 1'b0);
        send_symbol(1'b1, 1'b0, 1'b0);
        send_symbol(1'b0, 1'b1, 1'b1);
        write_order(3'd7);
        send_symbol(1'b1, 1'b0, 1'b0);
        send_symbol(1'b0, 1'b1, 1'b0);
        send_symbol(1'b0, 1'b0, 1'b0);
        send_symbol(1'b1, 1'b0, 1'b0);
        send_symbol(1'b1, 1'b0, 1'b0);
        send_symbol(1'b0, 1'b0, 1'b0);
        send_symbol(1'b0, 1'b0, 1'b1);
    endtask

    // Lower the order with bits held: the surplus leaves at once on the next symbol
    task automatic test_order_lowered();
        write_order(3'd4);
        send_symbol(1'b1, 1'b0, 1'b0);
        send_symbol(1'b0, 1'b1, 1'b0);
        send_symbol(1'b1, 1'b0, 1'b0);
        write_order(3'd2);
        send_symbol(1'b0, 1'b0, 1'b0);
        send_symbol(1'b0, 1'b0, 1'b1);
    endtask

    // Mostly alternating marks with violations and zero runs, across random orders
    task automatic test_random_traffic();
        int   phase;
        int   idx;
        int   pick;
        logic p;
        logic q;
        logic e;
        for (phase = 0; phase < 5; phase++)
        begin
            write_order(ORDER_W'($urandom_range(0, 7)));
            for (idx = 0; idx < 77; idx++)
            begin
                pick = $urandom_range(0, 15);
                if (pick < 5)
                begin
                    p = 1'b0;
                    q = 1'b0;
                end
                else if (pick < 11)
                begin
                    p = (line_pol == POL_NEG);
                    q = ~p;
                end
                else if (pick < 14)
                begin
                    p = (line_pol == POL_POS);
                    q = ~p;
                end
                else if (pick == 14)
                begin
                    p = 1'b1;
                    q = 1'b1;
                end
                else
                begin
                    p = 1'($urandom_range(0, 1));
                    q = 1'($urandom_range(0, 1));
                end
                e = ($urandom_range(0, 15) == 0);
                send_symbol(p, q, e);
            end
            send_symbol(1'b0, 1'b0, 1'b1);
        end
    endtask

    // Stall the result side at random
    initial
    begin : result_side
        int w;
        @(posedge clk);
        forever
        begin
            w = draw_wait(out_calm);
            if (w > 0)
            begin
                out_stall <= 1'b1;
                repeat (w) @(posedge clk);
                out_stall <= 1'b0;
            end
            do
            begin
                @(posedge clk);
            end
            while (!(out_valid && !out_stall));
        end
    end

    // Compare each accepted bit with the oldest expectation
    always @(posedge clk)
    begin : check_result
        res_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_bits.size() == 0)
            begin
                fail_count++;
                if (fail_count <= 10)
                    $display("unexpected bit: got bit %0b last %0b", decoded_bit, last_of_run);
            end
            else
            begin
                want = expected_bits.pop_front();
                if (want.decoded_bit !== decoded_bit || want.last_of_run !== last_of_run)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("mismatch: expected bit %0b last %0b, got bit %0b last %0b",
                                 want.decoded_bit, want.last_of_run, decoded_bit, last_of_run);
                end
            end
        end
    end

    initial
    begin
        int spin;
        clear_line();
        order_sel = ORDER_RESET;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_defaults();
        test_order_saturation();
        test_order_lowered();
        test_random_traffic();
        // drain the remaining bits, then watch for strays
        in_valid <= 1'b0;
        spin = 0;
        while (expected_bits.size() != 0 && spin < 5000)
        begin
            @(posedge clk);
            spin++;
        end
        if (expected_bits.size() != 0)
        begin
            $display("%0d expected bits never arrived", expected_bits.size());
            fail_count++;
        end
        repeat (16) @(posedge clk);
        if (fail_count == 0)
            $display("[hdbn_line_decoder] OK");
        else
            $display("[hdbn_line_decoder] ERROR");
        $finish;
    end

    // Hard stop if the run hangs
    initial
    begin
        #2000000;
        $display("[hdbn_line_decoder] ERROR");
        $finish;
    end

endmodule

// ===== hdbn_line_decoder.f =====
+incdir+src
src/hdbn_pkg.sv
src/hdbn_sym_dec.sv
src/hdbn_res_buf.sv
src/hdbn_line_decoder.sv
src/hdbn_chk.sv
verif/tb_top.sv
